FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions that are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define EMND_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define EMND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/emnd_pkg.sv
// ----------------------------------------------------------------------------
// emnd_pkg
// Shared types and constants of the neighbor difference edge block.
// ----------------------------------------------------------------------------
package emnd_pkg;

  localparam int unsigned PIXEL_BITS     = 8;
  localparam int unsigned WIDTH_REG_BITS = 11;
  localparam int unsigned WIDTH_RESET    = 1024;
  localparam int unsigned NBR_COUNT      = 8;
  localparam int unsigned OUT_DEPTH      = 4;
  localparam int unsigned OUT_PTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W      = $clog2(OUT_DEPTH + 1);

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic REG_IMAGE_WIDTH = 1'b0;

  typedef struct packed {
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] edge_value;
    logic                  last_pixel;
  } out_word_t;

  // Per-word control handed from the sequencer to the datapath.
  typedef struct packed {
    logic                 valid;
    logic                 is_pixel;
    logic                 emit;
    logic                 last;
    logic [NBR_COUNT-1:0] nbr_en;
  } iss_ctrl_t;

endpackage

FILE: rtl/edge_max_neighbor_difference_top.sv
// ----------------------------------------------------------------------------
// edge_max_neighbor_difference_top
// 3x3 edge strength: largest absolute difference to any existing neighbor.
// ----------------------------------------------------------------------------
// Pixels arrive one word per clock in raster order, each row image_width
// pixels long; while the output side is ready the block sustains one word
// per clock on both sides. For every pixel it returns the largest absolute
// difference between that pixel and those of its eight neighbors that lie
// inside the image; rows above the first, columns beyond either edge and
// positions after the final pixel do not count, so a short last row is
// fine. The result of stream position p goes out with the processing of
// word p + W + 1 and passes s1, s2 and the queue. After the last pixel,
// send drain words (command = 1) until the result marked last_pixel appears;
// that result returns the stream logic to its start state, so the next pixel
// begins a new image. Drain words with nothing pending are swallowed. Two
// previous rows live in one line memory of MAX_WIDTH entries, read and
// written back once per word; a write to image_width restarts the stream
// and drops pending results, and is meant to be made only while the block
// is idle. There is no clearing pass after reset: unwritten memory entries
// are never used because a row is only consulted once it has really been
// received. The output queue holds four words; input ready drops only when
// results wait on a stalled output.
module edge_max_neighbor_difference_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input.
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  emnd_pkg::in_word_t  in_data_i,
  // Result output.
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output emnd_pkg::out_word_t out_data_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW   = emnd_pkg::WIDTH_REG_BITS;
  localparam int unsigned EW   = 17;
  localparam int unsigned SW   = emnd_pkg::OUT_CNT_W + 1;
  localparam int unsigned RSTW = (MAX_WIDTH < emnd_pkg::WIDTH_RESET) ?
                                 MAX_WIDTH : emnd_pkg::WIDTH_RESET;

  // Raw register value for read-back and the effective last column.
  logic [RW-1:0] width_q;
  logic [CW-1:0] last_col_q, last_col_d;
  logic [EW-1:0] wr_width;
  logic          cfg_wr;

  emnd_pkg::iss_ctrl_t                   iss;
  logic [CW-1:0]                         addr;
  logic                                  push;
  emnd_pkg::out_word_t                   res;
  logic [1:0]                            inflight;
  logic [emnd_pkg::OUT_CNT_W-1:0]        fifo_cnt;
  logic [SW-1:0]                         occupancy;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == emnd_pkg::REG_IMAGE_WIDTH);
  assign prdata = (paddr[2] == emnd_pkg::REG_IMAGE_WIDTH) ? 32'(width_q) : '0;

  // A width of zero behaves as one column, anything beyond the line memory
  // is clipped to its depth.
  always_comb begin
    wr_width = EW'(pwdata[RW-1:0]);
    if (wr_width == '0) begin
      last_col_d = '0;
    end else if (wr_width > EW'(MAX_WIDTH)) begin
      last_col_d = CW'(MAX_WIDTH - 1);
    end else begin
      last_col_d = CW'(wr_width - EW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RW'(emnd_pkg::WIDTH_RESET);
      last_col_q <= CW'(RSTW - 1);
    end else if (cfg_wr) begin
      width_q    <= pwdata[RW-1:0];
      last_col_q <= last_col_d;
    end
  end

  // Room for every result already on its way through the pipeline.
  assign occupancy  = SW'(fifo_cnt) + SW'(inflight);
  assign in_ready_o = (occupancy < SW'(emnd_pkg::OUT_DEPTH));

  emnd_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_wr),
    .last_col_i(last_col_q),
    .accept_i  (in_valid_i && in_ready_o),
    .cmd_i     (in_data_i.command),
    .iss_o     (iss),
    .addr_o    (addr)
  );

  emnd_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .iss_i     (iss),
    .addr_i    (addr),
    .pixel_i   (in_data_i.pixel_value),
    .push_o    (push),
    .res_o     (res),
    .inflight_o(inflight)
  );

  emnd_out_fifo u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data_o),
    .count_o(fifo_cnt)
  );

endmodule

FILE: rtl/emnd_ctrl.sv
// ----------------------------------------------------------------------------
// emnd_ctrl
// Stream sequencer: column and row tracking, pending count, drain handling
// and the presence flags of the 3x3 window.
// ----------------------------------------------------------------------------
module emnd_ctrl #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      restart_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] last_col_i,
  input  logic                                      accept_i,
  input  logic                                      cmd_i,
  output emnd_pkg::iss_ctrl_t                       iss_o,
  output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PW = $clog2(MAX_WIDTH + 3);

  logic [CW-1:0] col_q, col_d;
  logic [1:0]    rows_q, rows_d;
  logic [PW-1:0] pend_q, pend_d;
  logic          drain_q, drain_d;
  logic [8:0]    pres_q, pres_d;

  logic          take, drain_n, is_pix, win_ok, up_p, mid_p, emit, last;
  logic          left_ok, right_ok;
  logic [8:0]    pres_sh;
  logic [PW-1:0] pend1, pend2;
  logic [CW-1:0] centre;

  always_comb begin
    take    = accept_i && !(cmd_i == emnd_pkg::CMD_DRAIN && pend_q == '0);
    drain_n = drain_q || (cmd_i == emnd_pkg::CMD_DRAIN);
    is_pix  = !drain_n;
    win_ok  = (rows_q == 2'd2) || (rows_q == 2'd1 && col_q != '0);
    up_p    = (rows_q == 2'd2);
    mid_p   = (rows_q != 2'd0) && (is_pix || !win_ok || pend_q >= PW'(2));

    for (int r = 0; r < 3; r++) begin
      pres_sh[r*3]   = pres_q[r*3+1];
      pres_sh[r*3+1] = pres_q[r*3+2];
    end
    pres_sh[2] = up_p;
    pres_sh[5] = mid_p;
    pres_sh[8] = is_pix;

    pend1 = pend_q + PW'(is_pix);
    pend2 = pend1 - PW'(1);
    emit  = win_ok && (pend1 != '0);
    last  = emit && (pend2 == '0);

    // The centre pixel sits one column behind the incoming one.
    centre   = (col_q == '0) ? last_col_i : col_q - CW'(1);
    left_ok  = (centre != '0);
    right_ok = (centre != last_col_i);
  end

  always_comb begin
    col_d   = col_q;
    rows_d  = rows_q;
    pend_d  = pend_q;
    drain_d = drain_q;
    pres_d  = pres_q;
    if (restart_i) begin
      col_d   = '0;
      rows_d  = 2'd0;
      pend_d  = '0;
      drain_d = 1'b0;
      pres_d  = '0;
    end else if (take) begin
      if (last) begin
        col_d   = '0;
        rows_d  = 2'd0;
        pend_d  = '0;
        drain_d = 1'b0;
        pres_d  = '0;
      end else begin
        drain_d = drain_n;
        pres_d  = pres_sh;
        pend_d  = emit ? pend2 : pend1;
        if (col_q == last_col_i) begin
          col_d = '0;
          if (rows_q != 2'd2) begin
            rows_d = rows_q + 2'd1;
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      rows_q  <= 2'd0;
      pend_q  <= '0;
      drain_q <= 1'b0;
      pres_q  <= '0;
    end else begin
      col_q   <= col_d;
      rows_q  <= rows_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
      pres_q  <= pres_d;
    end
  end

  always_comb begin
    iss_o.valid     = take;
    iss_o.is_pixel  = is_pix;
    iss_o.emit      = emit;
    iss_o.last      = last;
    iss_o.nbr_en[0] = pres_sh[0] && left_ok;
    iss_o.nbr_en[1] = pres_sh[1];
    iss_o.nbr_en[2] = pres_sh[2] && right_ok;
    iss_o.nbr_en[3] = pres_sh[3] && left_ok;
    iss_o.nbr_en[4] = pres_sh[5] && right_ok;
    iss_o.nbr_en[5] = pres_sh[6] && left_ok;
    iss_o.nbr_en[6] = pres_sh[7];
    iss_o.nbr_en[7] = pres_sh[8] && right_ok;
    addr_o          = col_q;
  end

endmodule

FILE: rtl/emnd_datapath.sv
// ----------------------------------------------------------------------------
// emnd_datapath
// Line memory with read-modify-write and forwarding, the 3x3 window and the
// registered largest-difference stage.
// ----------------------------------------------------------------------------
module emnd_datapath #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  emnd_pkg::iss_ctrl_t                       iss_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] addr_i,
  input  logic [emnd_pkg::PIXEL_BITS-1:0]           pixel_i,
  output logic                                      push_o,
  output emnd_pkg::out_word_t                       res_o,
  output logic [1:0]                                inflight_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned PB = emnd_pkg::PIXEL_BITS;
  localparam int unsigned NB = emnd_pkg::NBR_COUNT;

  // Each entry holds {upper row, middle row} of one column.
  logic [2*PB-1:0] line_mem [MAX_WIDTH];
  logic [2*PB-1:0] rd_q, fwd_data_q, rd_eff, wdata;
  logic            fwd_q;

  logic            s1_v_q, s1_emit_q, s1_last_q;
  logic [CW-1:0]   s1_addr_q;
  logic [PB-1:0]   s1_bot_q;
  logic [NB-1:0]   s1_nbr_q;

  logic            s2_v_q, s2_last_q;
  logic [NB-1:0]   s2_nbr_q;

  logic [PB-1:0]   win_q [9];

  logic [PB-1:0]   diff [NB];
  logic [PB-1:0]   m0, m1, m2, m3, m01, m23, mx;

  // The word right ahead may write the entry this word has just read.
  assign rd_eff = fwd_q ? fwd_data_q : rd_q;
  assign wdata  = {rd_eff[PB-1:0], s1_bot_q};

  always_ff @(posedge clk_i) begin
    if (iss_i.valid) begin
      rd_q <= line_mem[addr_i];
    end
    if (s1_v_q) begin
      line_mem[s1_addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      fwd_data_q <= wdata;
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_eff[2*PB-1:PB];
      win_q[5] <= rd_eff[PB-1:0];
      win_q[8] <= s1_bot_q;
    end
    if (iss_i.valid) begin
      s1_addr_q <= addr_i;
      s1_bot_q  <= iss_i.is_pixel ? pixel_i : '0;
      s1_last_q <= iss_i.last;
      s1_nbr_q  <= iss_i.nbr_en;
    end
    s2_last_q <= s1_last_q;
    s2_nbr_q  <= s1_nbr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s1_emit_q <= 1'b0;
      s2_v_q    <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      s1_v_q    <= iss_i.valid;
      s1_emit_q <= iss_i.valid && iss_i.emit;
      s2_v_q    <= s1_v_q && s1_emit_q;
      fwd_q     <= iss_i.valid && s1_v_q && (s1_addr_q == addr_i);
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      logic [PB-1:0] nv;
      nv      = (i < 4) ? win_q[i] : win_q[i+1];
      diff[i] = !s2_nbr_q[i] ? '0 :
                (nv > win_q[4]) ? nv - win_q[4] : win_q[4] - nv;
    end
    m0  = (diff[0] > diff[1]) ? diff[0] : diff[1];
    m1  = (diff[2] > diff[3]) ? diff[2] : diff[3];
    m2  = (diff[4] > diff[5]) ? diff[4] : diff[5];
    m3  = (diff[6] > diff[7]) ? diff[6] : diff[7];
    m01 = (m0 > m1) ? m0 : m1;
    m23 = (m2 > m3) ? m2 : m3;
    mx  = (m01 > m23) ? m01 : m23;
  end

  assign push_o           = s2_v_q;
  assign res_o.edge_value = mx;
  assign res_o.last_pixel = s2_last_q;
  assign inflight_o       = 2'(s1_v_q && s1_emit_q) + 2'(s2_v_q);

endmodule

FILE: rtl/emnd_out_fifo.sv
// ----------------------------------------------------------------------------
// emnd_out_fifo
// Small result queue that decouples the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module emnd_out_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  emnd_pkg::out_word_t              data_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output emnd_pkg::out_word_t              data_o,
  output logic [emnd_pkg::OUT_CNT_W-1:0]   count_o
);

  localparam int unsigned PTRW = emnd_pkg::OUT_PTR_W;
  localparam int unsigned CNTW = emnd_pkg::OUT_CNT_W;

  emnd_pkg::out_word_t slot_q [emnd_pkg::OUT_DEPTH];
  logic [PTRW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]     cnt_q, cnt_d;
  logic                pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_d  = push_i ? wr_q + PTRW'(1) : wr_q;
    rd_d  = pop ? rd_q + PTRW'(1) : rd_q;
    cnt_d = cnt_q + CNTW'(push_i) - CNTW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: rtl/emnd_check.sv
// ----------------------------------------------------------------------------
// emnd_check
// Port-level checks of the edge block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module emnd_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input emnd_pkg::out_word_t out_data_o,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata
);

  // A stalled result word keeps its contents.
  `EMND_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // Input is only held off while results wait at the output.
  `EMND_ASSERT_SAME(a_ready_backlog, !in_ready_o, out_valid_o, "input stalled with no result waiting")

  // A width write reads back in the next cycle.
  `EMND_ASSERT_NEXT(a_width_readback, psel && penable && pwrite && (paddr[2] == emnd_pkg::REG_IMAGE_WIDTH), (paddr[2] != emnd_pkg::REG_IMAGE_WIDTH) || (prdata == 32'($past(pwdata[10:0]))), "image width read-back mismatch")

endmodule

bind edge_max_neighbor_difference_top emnd_check u_emnd_check (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata)
);
